>>> rtl/core/sscs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sscs_pkg: shared types and constants of the sparse-set component store
// Field widths, opcode and status codes, and the control/status bundles
// passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package sscs_pkg;

  // default sizing
  localparam int unsigned DEF_MAX_ENTITIES = 1024;
  localparam int unsigned DEF_NUM_TYPES    = 8;
  localparam int unsigned DEF_DATA_WIDTH   = 64;

  // fixed word field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned TYPE_W   = 3;
  localparam int unsigned EID_W    = 10;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned STATUS_W = 2;

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // sparse map write source
  typedef enum logic [1:0] {
    SP_CLEAR,  // reset sweep, write invalid
    SP_ADD,    // map[t][e] = count
    SP_MOVE,   // map[t][moved] = hole slot
    SP_DROP    // map[t][e] = invalid
  } sp_src_e;

  // sequencer -> datapath
  typedef struct packed {
    logic                in_ready;
    logic                clr_step;
    logic                sp_we;
    sp_src_e             sp_src;
    logic                dp_we;
    logic                dp_move;
    logic                rd_last;
    logic                idx_load;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                res_we;
    logic [STATUS_W-1:0] res_status;
    logic                res_take_data;
    logic                out_load;
  } sscs_ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic            in_fire;
    logic            clr_done;
    logic [OP_W-1:0] op;
    logic            req_bad;
    logic            cnt_zero;
    logic            cnt_full;
    logic            idx_oob;
    logic            dn_match;
    logic            idx_last;
    logic            out_free;
  } sscs_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/sscs_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sscs_req_if: request channel of the component store
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface sscs_req_if;
  import sscs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TYPE_W-1:0] comp_type;
  logic [EID_W-1:0]  entity_id;
  logic [DATA_W-1:0] payload_in;

  modport source (output valid, op, comp_type, entity_id, payload_in, input ready);
  modport sink   (input valid, op, comp_type, entity_id, payload_in, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sscs_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sscs_rsp_if: response channel of the component store
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface sscs_rsp_if;
  import sscs_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   payload_out;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, status, payload_out, entry_count, input ready);
  modport sink   (input valid, status, payload_out, entry_count, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sscs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sscs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sscs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/sscs_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sscs_seq: operation sequencer of the component store
// Steps one operation through the map, dense and payload memory accesses.
// ----------------------------------------------------------------------------
module sscs_seq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sscs_pkg::sscs_stat_t  stat_i,
  output sscs_pkg::sscs_ctrl_t       ctrl_o
);
  import sscs_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_ADD    = 4'd3;
  localparam logic [3:0] S_RDMAP  = 4'd4;
  localparam logic [3:0] S_CHK    = 4'd5;
  localparam logic [3:0] S_RDLAST = 4'd6;
  localparam logic [3:0] S_REMFIN = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    ctrl_o  = '0;
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.sp_we    = 1'b1;
        ctrl_o.sp_src   = SP_CLEAR;
        ctrl_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (stat_i.in_fire) state_d = S_DEC;
      end
      S_DEC: begin
        if (stat_i.req_bad) begin
          ctrl_o.res_we     = 1'b1;
          ctrl_o.res_status = ST_INVALID;
          state_d           = S_FIN;
        end else begin
          unique case (stat_i.op)
            OP_ADD: begin
              if (stat_i.cnt_full) begin
                ctrl_o.res_we     = 1'b1;
                ctrl_o.res_status = ST_FULL;
                state_d           = S_FIN;
              end else begin
                state_d = S_ADD;
              end
            end
            OP_REMOVE: begin
              if (stat_i.cnt_zero) begin
                ctrl_o.res_we     = 1'b1;
                ctrl_o.res_status = ST_OK;
                state_d           = S_FIN;
              end else begin
                state_d = S_RDMAP;
              end
            end
            default: begin
              state_d = S_RDMAP;
            end
          endcase
        end
      end
      S_ADD: begin
        ctrl_o.sp_we      = 1'b1;
        ctrl_o.sp_src     = SP_ADD;
        ctrl_o.dp_we      = 1'b1;
        ctrl_o.cnt_inc    = 1'b1;
        ctrl_o.res_we     = 1'b1;
        ctrl_o.res_status = ST_OK;
        state_d           = S_FIN;
      end
      S_RDMAP: begin
        ctrl_o.idx_load = 1'b1;
        if (stat_i.idx_oob) begin
          ctrl_o.res_we     = 1'b1;
          ctrl_o.res_status = ST_INVALID;
          state_d           = S_FIN;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        ctrl_o.rd_last = 1'b1;
        if (!stat_i.dn_match) begin
          ctrl_o.res_we     = 1'b1;
          ctrl_o.res_status = ST_INVALID;
          state_d           = S_FIN;
        end else if (stat_i.op == OP_GET) begin
          ctrl_o.res_we        = 1'b1;
          ctrl_o.res_status    = ST_OK;
          ctrl_o.res_take_data = 1'b1;
          state_d              = S_FIN;
        end else if (stat_i.idx_last) begin
          state_d = S_REMFIN;
        end else begin
          state_d = S_RDLAST;
        end
      end
      S_RDLAST: begin
        ctrl_o.sp_we   = 1'b1;
        ctrl_o.sp_src  = SP_MOVE;
        ctrl_o.dp_we   = 1'b1;
        ctrl_o.dp_move = 1'b1;
        state_d        = S_REMFIN;
      end
      S_REMFIN: begin
        ctrl_o.sp_we      = 1'b1;
        ctrl_o.sp_src     = SP_DROP;
        ctrl_o.cnt_dec    = 1'b1;
        ctrl_o.res_we     = 1'b1;
        ctrl_o.res_status = ST_OK;
        state_d           = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/sparse_set_component_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_set_component_store: per-type sparse sets with swap-remove
// Top level: memories, set counters, request/result registers and sequencer.
// ----------------------------------------------------------------------------
// One sparse set per component type. Each set maps entity -> dense slot in a
// sparse map, lists the owning entity of each slot and keeps a payload per
// slot. Add appends (no duplicate check; full set reports status 2), remove
// swaps the last entry into the hole, get returns the stored payload. After
// reset the block sweeps every sparse map entry to invalid, one entry per
// cycle; req ready stays low during the sweep, config writes are still
// taken. One word is handled at a time, from the accept to the next ready.
// An op rejected at decode (bad field, full set) or an empty remove ends
// there; an add writes the map, dense and payload entries together; get and
// remove follow the chain of dependent reads through the registered RAM
// ports: map entry, then dense/payload entry, then the last entry, then the
// map update. A map miss or dense mismatch ends the chain, a get ends at the
// payload, and the last entry moves only if it is not the one removed.
// A finished result sits in the output register, so an idle result sink only
// delays the next op when a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
module sparse_set_component_store #(
  parameter int unsigned MAX_ENTITIES = sscs_pkg::DEF_MAX_ENTITIES,
  parameter int unsigned NUM_TYPES    = sscs_pkg::DEF_NUM_TYPES,
  parameter int unsigned DATA_WIDTH   = sscs_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [sscs_pkg::CNT_W-1:0] cfg_wdata_i,
  sscs_req_if.sink                        req_i,
  sscs_rsp_if.source                      rsp_o
);
  import sscs_pkg::*;

  localparam int unsigned TW    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int unsigned EW    = $clog2(MAX_ENTITIES);
  localparam int unsigned CW    = $clog2(MAX_ENTITIES + 1);
  localparam int unsigned AW    = TW + EW;
  localparam int unsigned DEPTH = 1 << AW;

  sscs_ctrl_t ctrl;
  sscs_stat_t stat;

  // config
  logic [CNT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // latched request word
  logic [OP_W-1:0]       op_q;
  logic [TYPE_W-1:0]     type_q;
  logic [EID_W-1:0]      eid_q;
  logic [DATA_WIDTH-1:0] pay_q;
  logic                  in_fire;

  assign req_i.ready = ctrl.in_ready;
  assign in_fire     = req_i.valid && ctrl.in_ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= req_i.op;
      type_q <= req_i.comp_type;
      eid_q  <= req_i.entity_id;
      pay_q  <= DATA_WIDTH'(req_i.payload_in);
    end
  end

  // decoded request
  logic [TW-1:0] t_idx;
  logic [EW-1:0] e_slot;
  logic          type_ok;
  logic          ent_ok;
  logic          lim_ok;
  logic          op_ok;

  assign t_idx   = TW'(type_q);
  assign e_slot  = EW'(eid_q);
  assign type_ok = 32'(type_q) < 32'(NUM_TYPES);
  assign ent_ok  = 32'(eid_q) < 32'(MAX_ENTITIES);
  assign lim_ok  = {1'b0, eid_q} < limit_q;
  assign op_ok   = (op_q == OP_ADD) || (op_q == OP_REMOVE) || (op_q == OP_GET);

  // per-type entry counts
  logic [CW-1:0] cnt_q [NUM_TYPES];
  logic [CW-1:0] cnt_cur;
  logic [CW-1:0] last_cnt;

  assign cnt_cur  = type_ok ? cnt_q[t_idx] : '0;
  assign last_cnt = cnt_cur - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (ctrl.cnt_inc) begin
      cnt_q[t_idx] <= cnt_cur + CW'(1);
    end else if (ctrl.cnt_dec) begin
      cnt_q[t_idx] <= last_cnt;
    end
  end

  // reset sweep of the sparse map
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (ctrl.clr_step) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // memories
  logic                  sp_we;
  logic [AW-1:0]         sp_waddr;
  logic [CW-1:0]         sp_wdata;
  logic [CW-1:0]         sp_rdata;
  logic [AW-1:0]         dp_waddr;
  logic [AW-1:0]         dp_raddr;
  logic [EW-1:0]         dn_wdata;
  logic [EW-1:0]         dn_rdata;
  logic [DATA_WIDTH-1:0] pl_wdata;
  logic [DATA_WIDTH-1:0] pl_rdata;
  logic [CW-1:0]         idx_q;

  assign sp_we = ctrl.sp_we;

  always_comb begin
    case (ctrl.sp_src)
      SP_CLEAR: begin
        sp_waddr = clr_addr_q;
        sp_wdata = '1;
      end
      SP_ADD: begin
        sp_waddr = {t_idx, e_slot};
        sp_wdata = cnt_cur;
      end
      SP_MOVE: begin
        // entity taken from the last slot now lives in the hole
        sp_waddr = {t_idx, dn_rdata};
        sp_wdata = idx_q;
      end
      default: begin
        sp_waddr = {t_idx, e_slot};
        sp_wdata = '1;
      end
    endcase
  end

  // dense/payload write: append at count, or fill the hole from the last slot
  assign dp_waddr = {t_idx, EW'(ctrl.dp_move ? idx_q : cnt_cur)};
  assign dn_wdata = ctrl.dp_move ? dn_rdata : e_slot;
  assign pl_wdata = ctrl.dp_move ? pl_rdata : pay_q;

  // dense/payload read: slot from the map, then the last slot
  assign dp_raddr = {t_idx, EW'(ctrl.rd_last ? last_cnt : sp_rdata)};

  sscs_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_sparse_ram (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (sp_waddr),
    .wdata_i (sp_wdata),
    .raddr_i ({t_idx, e_slot}),
    .rdata_o (sp_rdata)
  );

  sscs_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_dense_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.dp_we),
    .waddr_i (dp_waddr),
    .wdata_i (dn_wdata),
    .raddr_i (dp_raddr),
    .rdata_o (dn_rdata)
  );

  sscs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl.dp_we),
    .waddr_i (dp_waddr),
    .wdata_i (pl_wdata),
    .raddr_i (dp_raddr),
    .rdata_o (pl_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.idx_load) begin
      idx_q <= sp_rdata;
    end
  end

  // pending result
  logic [STATUS_W-1:0] res_status_q;
  logic [DATA_W-1:0]   res_data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.res_we) begin
      res_status_q <= ctrl.res_status;
      res_data_q   <= ctrl.res_take_data ? DATA_W'(pl_rdata) : '0;
    end
  end

  // output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [DATA_W-1:0]   out_data_q;
  logic [CNT_W-1:0]    out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_count_q  <= CNT_W'(cnt_cur);  // count already updated by the op
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.payload_out = out_data_q;
  assign rsp_o.entry_count = out_count_q;

  // status to sequencer
  always_comb begin
    stat          = '0;
    stat.in_fire  = in_fire;
    stat.clr_done = (clr_addr_q == '1);
    stat.op       = op_q;
    stat.req_bad  = !type_ok || !ent_ok || !op_ok || ((op_q != OP_GET) && !lim_ok);
    stat.cnt_zero = (cnt_cur == '0);
    stat.cnt_full = (cnt_cur == CW'(MAX_ENTITIES));
    stat.idx_oob  = (sp_rdata >= cnt_cur);
    stat.dn_match = (dn_rdata == e_slot);
    stat.idx_last = (idx_q == last_cnt);
    stat.out_free = !out_valid_q || rsp_o.ready;
  end

  sscs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

endmodule
`default_nettype wire
